/* hdl/fss_pkg.sv */
// ----------------------------------------------------------------------------
// fss_pkg
// Types and constants shared by the FAT12 sector sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  // Field widths of the item and result beats
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned TADDR_W    = 13;
  localparam int unsigned TBYTE_W    = 8;
  localparam int unsigned CLUSTER_W  = 12;
  localparam int unsigned LBA_W      = 32;
  localparam int unsigned SPC_W      = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SPC        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'd1;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_OPEN    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  // FAT12 entry values
  localparam logic [CLUSTER_W-1:0] ENTRY_MASK = 12'hFFF;
  localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_OPEN,
    OP_ADVANCE
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [TADDR_W-1:0]    table_address;
    logic [TBYTE_W-1:0]    table_byte;
    logic [CLUSTER_W-1:0]  first_cluster;
  } cmd_t;

  typedef struct packed {
    logic [SPC_W-1:0] sectors_per_cluster;
    logic [LBA_W-1:0] data_start_lba;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD0,
    B_RD1,
    B_RD2,
    B_MUL,
    B_ADD
  } back_state_e;

endpackage

`default_nettype wire

/* hdl/fss_in_if.sv */
// ----------------------------------------------------------------------------
// fss_in_if
// Item channel of the sector sequencer: valid/ready plus the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface fss_in_if;
  logic                             valid;
  logic                             ready;
  logic [fss_pkg::FUNC_W-1:0]       func;
  logic [fss_pkg::TADDR_W-1:0]      table_address;
  logic [fss_pkg::TBYTE_W-1:0]      table_byte;
  logic [fss_pkg::CLUSTER_W-1:0]    first_cluster;

  modport source (
    output valid, func, table_address, table_byte, first_cluster,
    input  ready
  );

  modport sink (
    input  valid, func, table_address, table_byte, first_cluster,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/fss_out_if.sv */
// ----------------------------------------------------------------------------
// fss_out_if
// Result channel of the sector sequencer: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface fss_out_if;
  logic                             valid;
  logic                             ready;
  logic [fss_pkg::LBA_W-1:0]        sector_lba;
  logic                             chain_ended;
  logic [fss_pkg::CLUSTER_W-1:0]    cluster;

  modport source (
    output valid, sector_lba, chain_ended, cluster,
    input  ready
  );

  modport sink (
    input  valid, sector_lba, chain_ended, cluster,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/fss_front.sv */
// ----------------------------------------------------------------------------
// fss_front
// Accepts item beats, classifies the function code and queues commands for the known codes.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  fss_in_if.sink         in_if,
  output fss_pkg::cmd_t  cmd_o,
  output logic           cmd_valid_o,
  input  wire logic      cmd_pop_i
);

  fss_pkg::cmd_t                  queue_q [fss_pkg::QUEUE_DEPTH];
  logic [fss_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [fss_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [fss_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                           accept;
  logic                           push;
  logic                           pop;
  logic                           known;
  fss_pkg::cmd_t                  cmd_in;

  assign in_if.ready = (count_q != fss_pkg::QCNT_W'(fss_pkg::QUEUE_DEPTH));
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    known                = 1'b1;
    cmd_in.op            = fss_pkg::OP_LOAD;
    cmd_in.table_address = in_if.table_address;
    cmd_in.table_byte    = in_if.table_byte;
    cmd_in.first_cluster = in_if.first_cluster;
    case (in_if.func)
      fss_pkg::FUNC_LOAD:    cmd_in.op = fss_pkg::OP_LOAD;
      fss_pkg::FUNC_OPEN:    cmd_in.op = fss_pkg::OP_OPEN;
      fss_pkg::FUNC_ADVANCE: cmd_in.op = fss_pkg::OP_ADVANCE;
      default:               known     = 1'b0;  // drop the unused code
    endcase
  end

  assign push = accept && known;
  assign pop  = cmd_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_o       = queue_q[rd_ptr_q];
  assign cmd_valid_o = (count_q != '0);

endmodule

`default_nettype wire

/* hdl/fss_back.sv */
// ----------------------------------------------------------------------------
// fss_back
// Executes queued commands: table writes, chain open and sector advance,
// with the allocation table held in a single-port memory.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_back #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fss_pkg::cfg_t  cfg_i,
  input  wire fss_pkg::cmd_t  cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  fss_out_if.source           out_if
);

  localparam int unsigned AW    = $clog2(TABLE_BYTES);
  localparam int unsigned PROD_W = fss_pkg::CLUSTER_W + 1 + fss_pkg::SPC_W + 1;

  logic [fss_pkg::TBYTE_W-1:0]    mem [TABLE_BYTES];
  logic [fss_pkg::TBYTE_W-1:0]    rdata_q;
  logic [fss_pkg::TADDR_W-1:0]    mem_addr;
  logic                           mem_we;
  logic                           addr_oob;

  fss_pkg::back_state_e           state_q, state_d;
  logic [fss_pkg::CLUSTER_W-1:0]  cur_q, cur_d;
  logic [fss_pkg::SPC_W-1:0]      sec_q, sec_d;
  logic                           is_adv_q, is_adv_d;
  logic                           rd_oob_q, rd_oob_d;
  logic [fss_pkg::TBYTE_W-1:0]    lo_q, lo_d;
  logic signed [PROD_W-1:0]       prod_q, prod_d;

  logic                           out_valid_q, out_valid_d;
  logic [fss_pkg::LBA_W-1:0]      out_lba_q, out_lba_d;
  logic                           out_ended_q, out_ended_d;
  logic [fss_pkg::CLUSTER_W-1:0]  out_cluster_q, out_cluster_d;

  logic [fss_pkg::TADDR_W-1:0]    entry_off;
  logic [fss_pkg::SPC_W:0]        sec_inc;
  logic [fss_pkg::TBYTE_W-1:0]    hi_byte;
  logic [2*fss_pkg::TBYTE_W-1:0]  entry_word;
  logic signed [fss_pkg::CLUSTER_W:0] rel;
  logic                           ended;
  logic                           out_free;

  // byte offset of the packed entry: cluster * 3 / 2
  assign entry_off  = fss_pkg::TADDR_W'(({2'b00, cur_q} * 14'd3) >> 1);
  assign sec_inc    = {1'b0, sec_q} + 1'b1;
  assign hi_byte    = rd_oob_q ? '0 : rdata_q;
  assign entry_word = {hi_byte, lo_q};
  assign rel        = $signed({1'b0, cur_q}) - 13'sd2;
  assign addr_oob   = ({1'b0, mem_addr} >= (fss_pkg::TADDR_W + 1)'(TABLE_BYTES));
  assign ended      = is_adv_q && (cur_q >= fss_pkg::END_MARK);
  assign out_free   = !out_valid_q || out_if.ready;

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    sec_d         = sec_q;
    is_adv_d      = is_adv_q;
    rd_oob_d      = rd_oob_q;
    lo_d          = lo_q;
    prod_d        = prod_q;
    out_valid_d   = out_valid_q && !out_if.ready;
    out_lba_d     = out_lba_q;
    out_ended_d   = out_ended_q;
    out_cluster_d = out_cluster_q;
    cmd_pop_o     = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = cmd_i.table_address;

    case (state_q)
      fss_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            fss_pkg::OP_LOAD: begin
              mem_we = !addr_oob;
            end
            fss_pkg::OP_OPEN: begin
              cur_d    = cmd_i.first_cluster;
              sec_d    = '0;
              is_adv_d = 1'b0;
              state_d  = fss_pkg::B_MUL;
            end
            fss_pkg::OP_ADVANCE: begin
              is_adv_d = 1'b1;
              if (sec_inc >= {1'b0, cfg_i.sectors_per_cluster}) begin
                sec_d   = '0;
                state_d = fss_pkg::B_RD0;
              end else begin
                sec_d   = sec_inc[fss_pkg::SPC_W-1:0];
                state_d = fss_pkg::B_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      fss_pkg::B_RD0: begin
        mem_addr = entry_off;
        rd_oob_d = addr_oob;
        state_d  = fss_pkg::B_RD1;
      end
      fss_pkg::B_RD1: begin
        // capture the low byte, fetch the high byte
        lo_d     = rd_oob_q ? '0 : rdata_q;
        mem_addr = entry_off + 1'b1;
        rd_oob_d = addr_oob;
        state_d  = fss_pkg::B_RD2;
      end
      fss_pkg::B_RD2: begin
        cur_d   = cur_q[0] ? entry_word[15:4] : entry_word[11:0];
        state_d = fss_pkg::B_MUL;
      end
      fss_pkg::B_MUL: begin
        prod_d  = PROD_W'(rel) * PROD_W'($signed({1'b0, cfg_i.sectors_per_cluster}));
        state_d = fss_pkg::B_ADD;
      end
      fss_pkg::B_ADD: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_ended_d   = ended;
          out_cluster_d = cur_q & fss_pkg::ENTRY_MASK;
          out_lba_d     = ended ? '0 :
                          cfg_i.data_start_lba
                          + {{(fss_pkg::LBA_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}
                          + {{(fss_pkg::LBA_W-fss_pkg::SPC_W){1'b0}}, sec_q};
          state_d       = fss_pkg::B_IDLE;
        end
      end
      default: state_d = fss_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fss_pkg::B_IDLE;
      cur_q       <= '0;
      sec_q       <= '0;
      is_adv_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      sec_q       <= sec_d;
      is_adv_q    <= is_adv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_oob_q      <= rd_oob_d;
    lo_q          <= lo_d;
    prod_q        <= prod_d;
    out_lba_q     <= out_lba_d;
    out_ended_q   <= out_ended_d;
    out_cluster_q <= out_cluster_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr[AW-1:0]] <= cmd_i.table_byte;
    end
    rdata_q <= mem[mem_addr[AW-1:0]];
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.sector_lba  = out_lba_q;
  assign out_if.chain_ended = out_ended_q;
  assign out_if.cluster     = out_cluster_q;

endmodule

`default_nettype wire

/* hdl/fat12_sector_sequencer.sv */
// ----------------------------------------------------------------------------
// fat12_sector_sequencer
// Walks a FAT12 cluster chain one sector at a time over a loadable table.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue and are executed in order by a
// sequencer. A load beat writes one table byte; an open goes through the
// multiply and add states, and an advance does the same, or first reads the
// FAT12 entry when it crosses into the next cluster: the two table bytes of
// the entry come one after the other from the single-port table memory,
// which has a registered read, and the sector address goes through a
// registered multiply and an add. The result sits in an output register, so
// the queue keeps taking beats, until it is full, while it waits. Table bytes
// that were never loaded read back as arbitrary data; the table needs no clearing pass after reset.
`default_nettype none

module fat12_sector_sequencer #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fss_in_if.sink                               in_if,
  fss_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [fss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fss_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  fss_pkg::cfg_t  cfg_q, cfg_d;
  fss_pkg::cmd_t  cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fss_pkg::REG_SPC:        cfg_d.sectors_per_cluster = cfg_wdata_i[fss_pkg::SPC_W-1:0];
        fss_pkg::REG_DATA_START: cfg_d.data_start_lba      = cfg_wdata_i[fss_pkg::LBA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sectors_per_cluster <= fss_pkg::SPC_W'(1);
      cfg_q.data_start_lba      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  fss_back #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .out_if      (out_if)
  );

  // an end-of-chain beat carries a zero address and a marker cluster
  a_end_lba_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.chain_ended |-> out_if.sector_lba == '0)
    else $error("end-of-chain beat with nonzero sector address");

  a_end_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.chain_ended |-> out_if.cluster >= fss_pkg::END_MARK)
    else $error("end-of-chain beat without a marker cluster");

  // the back end pops only from a nonempty queue
  a_queue_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire
